// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is low
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication with the consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

	// bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE       = 5'd0,
		PH_START_HOLD = 5'd1,
		PH_BIT_LOW    = 5'd2,
		PH_BIT_HIGH   = 5'd3,
		PH_ACK_LOW    = 5'd4,
		PH_ACK_HIGH   = 5'd5,
		PH_HS_A       = 5'd6,
		PH_HS_B       = 5'd7,
		PH_HS_C       = 5'd8,
		PH_HS_D       = 5'd9,
		PH_RD_LOW     = 5'd10,
		PH_RD_HIGH    = 5'd11,
		PH_RA_LOW     = 5'd12,
		PH_RA_HIGH    = 5'd13,
		PH_STOP_A     = 5'd14,
		PH_STOP_B     = 5'd15
	} phase_t;

	// command codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;
	localparam logic [2:0] OP_HS    = 3'd5;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

	// one result of the engine
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       ack;
	} res_t;

endpackage

// ----- rtl/i2c_master_byte_engine.sv -----
// a result is on the output in the cycle after its tick is accepted
// throughput: one tick per cycle unless the output stalls (single registered
// state update); the output register is refilled in the cycle it is drained
// reset (arst_n low, asynchronous): bus idle, scl and sda released in the core
// (output payload not reset), no result pending, half_period back to 10
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  tx_byte,
	input  logic        last_read,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_drive,
	output logic        sda_drive,
	output logic        busy_res,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic        ack_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0]    half_period_q;
	logic           step_en;
	i2cm_pkg::res_t res_d;
	i2cm_pkg::res_t res_q;

	// configuration register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cm_pkg::HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			half_period_q <= cfg_data;
		end
	end

	assign step_en = in_valid && in_ready;

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.operation   (operation),
		.tx_byte     (tx_byte),
		.last_read   (last_read),
		.sda_in      (sda_in),
		.half_period (half_period_q),
		.res         (res_d)
	);

	i2cm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_d     (res_d),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// result fields onto the ports
	assign scl_drive  = res_q.scl;
	assign sda_drive  = res_q.sda;
	assign busy_res   = res_q.busy;
	assign rx_byte    = res_q.rx_byte;
	assign rx_valid   = res_q.rx_valid;
	assign ack_status = res_q.ack;

endmodule

// ----- rtl/i2cm_core.sv -----
module i2cm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [2:0]        operation,
	input  logic [7:0]        tx_byte,
	input  logic              last_read,
	input  logic              sda_in,
	input  logic [15:0]       half_period,
	output i2cm_pkg::res_t    res
);

	i2cm_pkg::phase_t ph_q, ph_d;
	logic [3:0]  bc_q, bc_d;
	logic [16:0] dc_q, dc_d;
	logic [7:0]  sr_q, sr_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_q, ack_d;
	logic        last_q, last_d;
	logic [2:0]  cmd_q, cmd_d;
	logic [7:0]  rx_q, rx_d;
	logic        valid_d;
	logic [16:0] t_full;

	assign t_full = {1'b0, half_period};

	// state registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= i2cm_pkg::PH_IDLE;
			bc_q   <= '0;
			dc_q   <= '0;
			sr_q   <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			ack_q  <= 1'b0;
			last_q <= 1'b0;
			cmd_q  <= i2cm_pkg::OP_TICK;
			rx_q   <= '0;
		end else if (step_en) begin
			ph_q   <= ph_d;
			bc_q   <= bc_d;
			dc_q   <= dc_d;
			sr_q   <= sr_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
			ack_q  <= ack_d;
			last_q <= last_d;
			cmd_q  <= cmd_d;
			rx_q   <= rx_d;
		end
	end

	// next state: command issue, delay countdown or phase action
	always_comb begin
		ph_d    = ph_q;
		bc_d    = bc_q;
		dc_d    = dc_q;
		sr_d    = sr_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		last_d  = last_q;
		cmd_d   = cmd_q;
		rx_d    = rx_q;
		valid_d = 1'b0;
		if (ph_q == i2cm_pkg::PH_IDLE) begin
			// new command only from the idle phase
			if (operation == i2cm_pkg::OP_START || operation == i2cm_pkg::OP_HS) begin
				cmd_d = operation;
				bc_d  = '0;
				sr_d  = tx_byte;
				sda_d = 1'b0;
				dc_d  = t_full;
				ph_d  = i2cm_pkg::PH_START_HOLD;
			end else if (operation == i2cm_pkg::OP_WRITE) begin
				cmd_d = operation;
				bc_d  = '0;
				sr_d  = tx_byte;
				sda_d = tx_byte[7];
				dc_d  = t_full;
				ph_d  = i2cm_pkg::PH_BIT_LOW;
			end else if (operation == i2cm_pkg::OP_READ) begin
				cmd_d  = operation;
				bc_d   = '0;
				sr_d   = '0;
				last_d = last_read;
				dc_d   = t_full;
				ph_d   = i2cm_pkg::PH_RD_LOW;
			end else if (operation == i2cm_pkg::OP_STOP) begin
				cmd_d = operation;
				bc_d  = '0;
				sda_d = 1'b0;
				dc_d  = t_full + 17'd1;
				ph_d  = i2cm_pkg::PH_STOP_A;
			end
		end else if (dc_q != '0) begin
			dc_d = dc_q - 17'd1;
		end else begin
			case (ph_q)
				i2cm_pkg::PH_START_HOLD: begin
					scl_d = 1'b0;
					sda_d = sr_q[7];
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_BIT_LOW;
				end
				i2cm_pkg::PH_BIT_LOW: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_BIT_HIGH;
				end
				i2cm_pkg::PH_BIT_HIGH: begin
					scl_d = 1'b0;
					sr_d  = {sr_q[6:0], 1'b0};
					bc_d  = bc_q + 4'd1;
					if (bc_d < i2cm_pkg::BITS_PER_BYTE) begin
						sda_d = sr_d[7];
						dc_d  = t_full;
						ph_d  = i2cm_pkg::PH_BIT_LOW;
					end else if (cmd_q == i2cm_pkg::OP_HS) begin
						dc_d = t_full;
						ph_d = i2cm_pkg::PH_HS_A;
					end else begin
						// release sda for the ack clock, margin wait
						sda_d = 1'b1;
						dc_d  = t_full + 17'd1;
						ph_d  = i2cm_pkg::PH_ACK_LOW;
					end
				end
				i2cm_pkg::PH_ACK_LOW: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_ACK_HIGH;
				end
				i2cm_pkg::PH_ACK_HIGH: begin
					if (cmd_q == i2cm_pkg::OP_START) begin
						ack_d = sda_in;
					end
					scl_d = 1'b0;
					dc_d  = '0;
					ph_d  = i2cm_pkg::PH_IDLE;
				end
				i2cm_pkg::PH_HS_A: begin
					sda_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_HS_B;
				end
				i2cm_pkg::PH_HS_B: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_HS_C;
				end
				i2cm_pkg::PH_HS_C: begin
					scl_d = 1'b0;
					dc_d  = t_full + t_full;
					ph_d  = i2cm_pkg::PH_HS_D;
				end
				i2cm_pkg::PH_HS_D: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_STOP_B;
				end
				i2cm_pkg::PH_RD_LOW: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_RD_HIGH;
				end
				i2cm_pkg::PH_RD_HIGH: begin
					// sample on the falling scl edge
					sr_d  = {sr_q[6:0], sda_in};
					scl_d = 1'b0;
					bc_d  = bc_q + 4'd1;
					if (bc_d < i2cm_pkg::BITS_PER_BYTE) begin
						dc_d = t_full + 17'd1;
						ph_d = i2cm_pkg::PH_RD_LOW;
					end else begin
						rx_d    = sr_d;
						valid_d = 1'b1;
						if (!last_q) begin
							sda_d = 1'b0;
						end
						dc_d = t_full;
						ph_d = i2cm_pkg::PH_RA_LOW;
					end
				end
				i2cm_pkg::PH_RA_LOW: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_RA_HIGH;
				end
				i2cm_pkg::PH_RA_HIGH: begin
					scl_d = 1'b0;
					if (!last_q) begin
						sda_d = 1'b1;
					end
					dc_d = '0;
					ph_d = i2cm_pkg::PH_IDLE;
				end
				i2cm_pkg::PH_STOP_A: begin
					scl_d = 1'b1;
					dc_d  = t_full;
					ph_d  = i2cm_pkg::PH_STOP_B;
				end
				i2cm_pkg::PH_STOP_B: begin
					sda_d = 1'b1;
					dc_d  = '0;
					ph_d  = i2cm_pkg::PH_IDLE;
				end
				default: begin
					dc_d = '0;
					ph_d = i2cm_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// result of this tick, taken from the next state
	always_comb begin
		res.scl      = scl_d;
		res.sda      = sda_d;
		res.busy     = (ph_d != i2cm_pkg::PH_IDLE);
		res.rx_byte  = rx_d;
		res.rx_valid = valid_d;
		res.ack      = ack_d;
	end

endmodule

// ----- rtl/i2cm_out_reg.sv -----
module i2cm_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2cm_pkg::res_t res_d,
	output logic           out_valid,
	input  logic           out_ready,
	output i2cm_pkg::res_t res_q
);

	logic valid_q;

	// slot is free when empty or drained this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/i2cm_checker.sv -----
`include "assert_macros.svh"

module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        scl_drive,
	input logic        sda_drive,
	input logic        busy_res,
	input logic [7:0]  rx_byte,
	input logic        rx_valid,
	input logic        ack_status
);

	logic [12:0] res_bits;
	logic        out_stall;
	logic        rx_done;

	// result payload as one vector, stall and read completion terms
	assign res_bits  = {scl_drive, sda_drive, busy_res, rx_byte, rx_valid, ack_status};
	assign out_stall = out_valid && !out_ready;
	assign rx_done   = out_valid && rx_valid;

	// a stalled result holds its payload
	`CHK_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(res_bits), "stalled result changed")

	// every accepted tick yields a result in the next cycle
	`CHK_NEXT(a_in_to_out, clk, arst_n, in_valid && in_ready, out_valid, "accepted tick gave no result")

	// a read byte completes on the scl falling edge inside a busy command
	`CHK_ASSERT(a_rx_in_cmd, clk, arst_n, rx_done |-> busy_res && !scl_drive, "read byte outside a command")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.scl_drive  (scl_drive),
	.sda_drive  (sda_drive),
	.busy_res   (busy_res),
	.rx_byte    (rx_byte),
	.rx_valid   (rx_valid),
	.ack_status (ack_status)
);
